// ----- rtl/ssrg_pkg.sv -----
package ssrg_pkg;

   localparam int MOTORS_DEF = 16;
   localparam int DELAY_W    = 17;
   localparam int CMP_W      = 16;
   localparam int WORD_W     = 32;
   // divider magnitude width: covers |2*d + r| and |4*n + 1|
   localparam int DIV_W      = 34;
   localparam logic [DELAY_W-1:0] DELAY_MAX = 17'h1FFFF;

   typedef enum logic [1:0] {
      PH_STOP  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_RUN   = 2'd2,
      PH_DECEL = 2'd3
   } phase_type;

   typedef enum logic {
      OP_EVENT = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [3:0]                motor;
      logic [DELAY_W-1:0]        start_delay;
      logic [DELAY_W-1:0]        fast_delay;
      logic [WORD_W-1:0]         decel_begin;
      logic signed [WORD_W-1:0]  decel_count;
      logic signed [WORD_W-1:0]  start_count;
      phase_type                 start_phase;
      logic                      direction;
   } req_type;

   typedef struct packed {
      logic [3:0]                motor_out;
      logic [CMP_W-1:0]          compare_value;
      logic                      pulse_done;
      phase_type                 phase;
      logic [DELAY_W-1:0]        next_delay;
      logic signed [WORD_W-1:0]  position;
      logic                      moving;
      logic                      channel_off;
      logic                      finished;
   } rsp_type;

   typedef struct packed {
      logic                      half_pulse;
      phase_type                 ramp_phase;
      logic [DELAY_W-1:0]        cur_delay;
      logic [DELAY_W-1:0]        top_delay;
      logic [WORD_W-1:0]         decel_point;
      logic [WORD_W-1:0]         decel_load;
      logic [WORD_W-1:0]         ramp_count;
      logic [WORD_W-1:0]         remainder;
      logic [WORD_W-1:0]         steps_taken;
      logic [DELAY_W-1:0]        last_ramp_delay;
      logic [WORD_W-1:0]         abs_position;
      logic                      busy_lock;
      logic                      motion_flag;
      logic                      dir_bit;
      logic [CMP_W-1:0]          compare_reg;
   } motor_state_type;

endpackage

// ----- rtl/ssrg_if.sv -----
interface ssrg_req_if;
   import ssrg_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ssrg_rsp_if;
   import ssrg_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ssrg_ram.sv -----
module ssrg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/stepper_speed_ramp_generator.sv -----
// Trapezoidal speed ramp generator for up to MOTORS stepper motors.
// req_chan carries one item per transfer: a start item loads a motor's move
// profile, a compare event advances that motor's compare value and, on every
// second event, completes a step and runs the ramp phase machine.
// rsp_chan returns exactly one result per item, in order.
// A start item, a non-step event or a step in stop or run passes S_READ, S_LOAD
// and S_DONE; a step in accel or decel adds S_DIV, the bit-serial divider (one
// quotient bit per cycle), and the S_FIX fix-up state; a motor index at or above
// MOTORS goes straight from S_IDLE to S_DONE.
// One item is processed at a time; req_chan.ready is high while no item is in
// work, so a new item is taken only once the last one has left S_DONE.
// Per-motor state sits in a RAM with one write port and one registered read
// port; a valid bit per motor makes an unwritten entry read as zero.
// Reset (synchronous) clears all motor state at once through the valid bits.
// The result waits in an output register; a new item is accepted while it
// waits, and processing holds at the end until that register is free.
// A motor index at or above MOTORS returns zeros besides the index.
module stepper_speed_ramp_generator #(
   parameter int MOTORS = ssrg_pkg::MOTORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ssrg_req_if.sink    req_chan,
   ssrg_rsp_if.source  rsp_chan
);
   import ssrg_pkg::*;

   localparam int AW    = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int SW    = $bits(motor_state_type);
   localparam int CNT_W = $clog2(DIV_W);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_LOAD, S_DIV, S_FIX, S_DONE
   } state_type;

   state_type            state_ff;
   req_type              item_ff;
   motor_state_type      work_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic                 bad_ff;
   logic                 pulse_ff, off_ff, fin_ff;
   logic [MOTORS-1:0]    valid_ff;
   logic [DIV_W-1:0]     dvd_ff;
   logic [DIV_W-1:0]     part_ff;
   logic [DIV_W-1:0]     dvs_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 qneg_ff, rneg_ff;

   logic [AW-1:0]        raddr, waddr;
   logic [SW-1:0]        rdata;
   logic                 we, slot_free, in_range;
   motor_state_type      rd_state;

   // divider and recurrence terms
   logic [WORD_W-1:0]         rc_inc, steps_inc, pos_inc;
   logic signed [DIV_W-1:0]   num, den;
   logic [DIV_W:0]            part_next;
   logic signed [DIV_W+1:0]   q_s, nd;
   logic [DIV_W-1:0]          r_mag;
   logic [DELAY_W-1:0]        nd_sat;
   logic                      nd_fits;

   assign in_range   = 32'(req_chan.data.motor) < MOTORS;
   assign raddr      = AW'(req_chan.data.motor);
   assign waddr      = AW'(item_ff.motor);
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign we         = (state_ff == S_DONE) && slot_free && !bad_ff;
   assign rd_state   = valid_ff[waddr] ? motor_state_type'(rdata) : '0;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   ssrg_ram #(.WIDTH(SW), .DEPTH(MOTORS)) u_state_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (SW'(work_ff)),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      rc_inc    = work_ff.ramp_count + 32'd1;
      steps_inc = work_ff.steps_taken + 32'd1;
      pos_inc   = work_ff.dir_bit ? work_ff.abs_position + 32'd1
                                  : work_ff.abs_position - 32'd1;
      num = DIV_W'({1'b0, work_ff.cur_delay, 1'b0})
          + DIV_W'(signed'(work_ff.remainder));
      den = {rc_inc, 2'b01};
      part_next = {part_ff, dvd_ff[DIV_W-1]};
      q_s   = qneg_ff ? -(DIV_W+2)'(dvd_ff) : (DIV_W+2)'(dvd_ff);
      r_mag = rneg_ff ? -part_ff : part_ff;
      nd    = (DIV_W+2)'(work_ff.cur_delay) - q_s;
      nd_fits = !nd[DIV_W+1] && (nd <= (DIV_W+2)'(DELAY_MAX));
      nd_sat  = nd_fits ? nd[DELAY_W-1:0] : DELAY_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  item_ff  <= req_chan.data;
                  bad_ff   <= !in_range;
                  pulse_ff <= 1'b0;
                  off_ff   <= 1'b0;
                  fin_ff   <= 1'b0;
                  state_ff <= in_range ? S_READ : S_DONE;
               end
            end
            S_READ: begin
               work_ff  <= rd_state;
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (item_ff.op == OP_START) begin
                  work_ff.cur_delay   <= item_ff.start_delay;
                  work_ff.top_delay   <= item_ff.fast_delay;
                  work_ff.decel_point <= item_ff.decel_begin;
                  work_ff.decel_load  <= item_ff.decel_count;
                  work_ff.ramp_count  <= item_ff.start_count;
                  work_ff.ramp_phase  <= item_ff.start_phase;
                  work_ff.dir_bit     <= item_ff.direction;
                  state_ff            <= S_DONE;
               end else begin
                  work_ff.compare_reg <= work_ff.compare_reg
                                       + CMP_W'(work_ff.cur_delay >> 1);
                  work_ff.half_pulse  <= !work_ff.half_pulse;
                  state_ff            <= S_DONE;
                  if (work_ff.half_pulse) begin
                     pulse_ff <= 1'b1;
                     unique case (work_ff.ramp_phase)
                        PH_STOP: begin
                           work_ff.steps_taken     <= '0;
                           work_ff.remainder       <= '0;
                           work_ff.last_ramp_delay <= '0;
                           work_ff.ramp_count      <= '0;
                           work_ff.top_delay       <= '0;
                           work_ff.cur_delay       <= '0;
                           off_ff                  <= 1'b1;
                           if (work_ff.busy_lock) begin
                              work_ff.motion_flag <= 1'b0;
                              work_ff.busy_lock   <= 1'b0;
                              fin_ff              <= 1'b1;
                           end
                        end
                        PH_RUN: begin
                           work_ff.steps_taken  <= steps_inc;
                           work_ff.abs_position <= pos_inc;
                           if (steps_inc >= work_ff.decel_point) begin
                              work_ff.ramp_count <= work_ff.decel_load;
                              work_ff.cur_delay  <= work_ff.last_ramp_delay;
                              work_ff.ramp_phase <= PH_DECEL;
                           end else begin
                              work_ff.cur_delay  <= work_ff.top_delay;
                           end
                        end
                        PH_ACCEL, PH_DECEL: begin
                           if (work_ff.ramp_phase == PH_ACCEL && !work_ff.busy_lock) begin
                              work_ff.motion_flag <= 1'b1;
                              work_ff.busy_lock   <= 1'b1;
                           end
                           work_ff.steps_taken  <= steps_inc;
                           work_ff.abs_position <= pos_inc;
                           work_ff.ramp_count   <= rc_inc;
                           // load magnitudes; signs fix up after the last bit
                           dvd_ff   <= num[DIV_W-1] ? -num : num;
                           dvs_ff   <= den[DIV_W-1] ? -den : den;
                           part_ff  <= '0;
                           qneg_ff  <= num[DIV_W-1] ^ den[DIV_W-1];
                           rneg_ff  <= num[DIV_W-1];
                           cnt_ff   <= '0;
                           state_ff <= S_DIV;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            S_DIV: begin
               // one restoring step per cycle: shift in, subtract if it fits
               if (part_next >= {1'b0, dvs_ff}) begin
                  part_ff <= DIV_W'(part_next - {1'b0, dvs_ff});
                  dvd_ff  <= {dvd_ff[DIV_W-2:0], 1'b1};
               end else begin
                  part_ff <= part_next[DIV_W-1:0];
                  dvd_ff  <= {dvd_ff[DIV_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_W - 1)) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               work_ff.remainder <= r_mag[WORD_W-1:0];
               work_ff.cur_delay <= nd_sat;
               if (work_ff.ramp_phase == PH_ACCEL) begin
                  if (work_ff.steps_taken >= work_ff.decel_point) begin
                     work_ff.ramp_count      <= work_ff.decel_load;
                     work_ff.ramp_phase      <= PH_DECEL;
                     work_ff.last_ramp_delay <= nd_sat;
                  end else if (nd_fits && nd[DELAY_W-1:0] <= work_ff.top_delay) begin
                     // top speed: keep the unclamped delay for the decel ramp
                     work_ff.ramp_count      <= work_ff.decel_load;
                     work_ff.last_ramp_delay <= nd[DELAY_W-1:0];
                     work_ff.cur_delay       <= work_ff.top_delay;
                     work_ff.remainder       <= '0;
                     work_ff.ramp_phase      <= PH_RUN;
                  end else begin
                     work_ff.last_ramp_delay <= nd_sat;
                  end
               end else if (!work_ff.ramp_count[WORD_W-1]) begin
                  work_ff.ramp_phase <= PH_STOP;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (slot_free) begin
                  if (bad_ff) begin
                     rsp_ff           <= '0;
                     rsp_ff.motor_out <= item_ff.motor;
                  end else begin
                     valid_ff[waddr]      <= 1'b1;
                     rsp_ff.motor_out     <= item_ff.motor;
                     rsp_ff.compare_value <= work_ff.compare_reg;
                     rsp_ff.pulse_done    <= pulse_ff;
                     rsp_ff.phase         <= work_ff.ramp_phase;
                     rsp_ff.next_delay    <= work_ff.cur_delay;
                     rsp_ff.position      <= work_ff.abs_position;
                     rsp_ff.moving        <= work_ff.motion_flag;
                     rsp_ff.channel_off   <= off_ff;
                     rsp_ff.finished      <= fin_ff;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_fin_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.finished |-> rsp_ff.channel_off)
      else $error("finished without channel_off");

   a_off_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.channel_off |-> rsp_ff.pulse_done)
      else $error("channel_off without a completed pulse");

   a_off_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.channel_off
      |-> rsp_ff.phase == PH_STOP && rsp_ff.next_delay == '0)
      else $error("stop handling left phase or delay set");

   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> 32'(cnt_ff) < DIV_W)
      else $error("divider count overrun");

endmodule

// ----- sim/stepper_speed_ramp_generator_tb.sv -----
`timescale 1ns / 100ps

module stepper_speed_ramp_generator_tb;
   import ssrg_pkg::*;

   localparam int PHASE_ITEMS = 500;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 400;

   class ramp_scoreboard;
      logic                half_q [16];
      phase_type           phase_q [16];
      logic [DELAY_W-1:0]  delay_q [16];
      logic [DELAY_W-1:0]  top_q [16];
      logic [WORD_W-1:0]   decel_at_q [16];
      logic [WORD_W-1:0]   decel_ld_q [16];
      logic [WORD_W-1:0]   count_q [16];
      logic [WORD_W-1:0]   rem_q [16];
      logic [WORD_W-1:0]   steps_q [16];
      logic [DELAY_W-1:0]  last_q [16];
      logic [WORD_W-1:0]   pos_q [16];
      logic                lock_q [16];
      logic                moving_q [16];
      logic                dir_q [16];
      logic [CMP_W-1:0]    cmp_q [16];
      rsp_type             pending_rsp [$];
      int                  errors;

      function new();
         errors = 0;
         for (int i = 0; i < 16; i++) begin
            half_q[i] = 0; phase_q[i] = PH_STOP; delay_q[i] = 0; top_q[i] = 0;
            decel_at_q[i] = 0; decel_ld_q[i] = 0; count_q[i] = 0; rem_q[i] = 0;
            steps_q[i] = 0; last_q[i] = 0; pos_q[i] = 0; lock_q[i] = 0;
            moving_q[i] = 0; dir_q[i] = 0; cmp_q[i] = 0;
         end
      endfunction

      function logic [DELAY_W-1:0] clamp_delay(longint v);
         return (v < 0 || v > longint'(DELAY_MAX)) ? DELAY_MAX : v[DELAY_W-1:0];
      endfunction

      // ramp recurrence; count must already be advanced
      function longint ramp_delay(int m);
         longint num, den, q;
         num = 2 * longint'(delay_q[m]) + longint'($signed(rem_q[m]));
         den = 4 * longint'($signed(count_q[m])) + 1;
         q = num / den;
         rem_q[m] = 32'(num % den);
         return longint'(delay_q[m]) - q;
      endfunction

      function void advance_step(int m);
         steps_q[m] = steps_q[m] + 1;
         pos_q[m] = dir_q[m] ? pos_q[m] + 1 : pos_q[m] - 1;
      endfunction

      function void note(req_type r);
         int      m;
         rsp_type e;
         longint  nd;
         m = int'(r.motor);
         e = '0;
         if (r.op == OP_START) begin
            delay_q[m] = r.start_delay;
            top_q[m] = r.fast_delay;
            decel_at_q[m] = r.decel_begin;
            decel_ld_q[m] = r.decel_count;
            count_q[m] = r.start_count;
            phase_q[m] = r.start_phase;
            dir_q[m] = r.direction;
         end else begin
            cmp_q[m] = cmp_q[m] + CMP_W'(delay_q[m] >> 1);
            half_q[m] = ~half_q[m];
            if (!half_q[m]) begin
               nd = 0;
               e.pulse_done = 1;
               case (phase_q[m])
                  PH_STOP: begin
                     steps_q[m] = 0; rem_q[m] = 0; last_q[m] = 0;
                     count_q[m] = 0; top_q[m] = 0;
                     e.channel_off = 1;
                     if (lock_q[m]) begin
                        moving_q[m] = 0;
                        lock_q[m] = 0;
                        e.finished = 1;
                     end
                  end
                  PH_ACCEL: begin
                     if (!lock_q[m]) begin
                        moving_q[m] = 1;
                        lock_q[m] = 1;
                     end
                     advance_step(m);
                     count_q[m] = count_q[m] + 1;
                     nd = ramp_delay(m);
                     if (steps_q[m] >= decel_at_q[m]) begin
                        count_q[m] = decel_ld_q[m];
                        phase_q[m] = PH_DECEL;
                        last_q[m] = clamp_delay(nd);
                     end else if (nd >= 0 && nd <= longint'(top_q[m])) begin
                        // top speed reached: keep the ramp delay for decel
                        count_q[m] = decel_ld_q[m];
                        last_q[m] = nd[DELAY_W-1:0];
                        nd = top_q[m];
                        rem_q[m] = 0;
                        phase_q[m] = PH_RUN;
                     end else begin
                        last_q[m] = clamp_delay(nd);
                     end
                  end
                  PH_RUN: begin
                     advance_step(m);
                     nd = top_q[m];
                     if (steps_q[m] >= decel_at_q[m]) begin
                        count_q[m] = decel_ld_q[m];
                        nd = last_q[m];
                        phase_q[m] = PH_DECEL;
                     end
                  end
                  default: begin
                     advance_step(m);
                     count_q[m] = count_q[m] + 1;
                     nd = ramp_delay(m);
                     if ($signed(count_q[m]) >= 0) phase_q[m] = PH_STOP;
                  end
               endcase
               delay_q[m] = clamp_delay(nd);
            end
         end
         e.motor_out = r.motor;
         e.compare_value = cmp_q[m];
         e.phase = phase_q[m];
         e.next_delay = delay_q[m];
         e.position = pos_q[m];
         e.moving = moving_q[m];
         pending_rsp.push_back(e);
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result expected none actual %h", $time, a);
            return;
         end
         e = pending_rsp.pop_front();
         field_check("motor_out", e.motor_out, a.motor_out);
         field_check("compare_value", e.compare_value, a.compare_value);
         field_check("pulse_done", e.pulse_done, a.pulse_done);
         field_check("phase", e.phase, a.phase);
         field_check("next_delay", e.next_delay, a.next_delay);
         field_check("position", e.position, a.position);
         field_check("moving", e.moving, a.moving);
         field_check("channel_off", e.channel_off, a.channel_off);
         field_check("finished", e.finished, a.finished);
      endfunction
   endclass

   logic clock;
   logic reset;
   ssrg_req_if req_bus ();
   ssrg_rsp_if rsp_bus ();
   ramp_scoreboard board;
   int tx_idle;
   int rx_idle;
   int items_sent;
   bit hold_done = 1'b0;
   int hold_left = 0;

   stepper_speed_ramp_generator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) board.note(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) board.check(rsp_bus.data);
      end
   end

   // receiver: random stalls plus one long hold-off to back up the block
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_sent == 200) begin
         rsp_bus.ready <= 0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
            stalled = 0;
         else
            stalled++;
      end
      $display("stepper_speed_ramp_generator_tb: errors");
      $finish;
   end

   function automatic req_type start_item(logic [3:0] m, logic [16:0] sd, logic [16:0] md,
                                          logic [31:0] ds, logic [31:0] dc, logic [31:0] sc,
                                          phase_type ph, logic dir);
      req_type r;
      r.op = OP_START; r.motor = m; r.start_delay = sd; r.fast_delay = md;
      r.decel_begin = ds; r.decel_count = dc; r.start_count = sc;
      r.start_phase = ph; r.direction = dir;
      return r;
   endfunction

   // profile fields are don't-care on events; fill them anyway
   function automatic req_type event_item(logic [3:0] m);
      req_type r;
      r = start_item(m, 17'($urandom), 17'($urandom), $urandom, $urandom, $urandom,
                     phase_type'($urandom_range(3)), 1'($urandom));
      r.op = OP_EVENT;
      return r;
   endfunction

   function automatic logic [31:0] neg_count();
      return -$urandom_range(0, 32'h7FFF_FFFF);
   endfunction

   task automatic push_item(input req_type it);
      while ($urandom_range(99) < tx_idle) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.data <= it;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic run_move();
      logic [3:0] m;
      int         steps, decel;
      m = 4'($urandom);
      steps = $urandom_range(1, 20);
      decel = $urandom_range(1, 15);
      push_item(start_item(m, 17'($urandom_range(50, 131071)), 17'($urandom_range(0, 3000)),
                           steps, -decel, -$urandom_range(0, 3),
                           ($urandom_range(9) == 0) ? PH_RUN : PH_ACCEL, 1'($urandom)));
      for (int i = 0; i < 2 * (steps + decel + 3); i++) push_item(event_item(m));
   endtask

   task automatic run_noise();
      req_type r;
      for (int i = 0; i < 10; i++) begin
         if ($urandom_range(1)) begin
            r = start_item(4'($urandom), 17'($urandom), 17'($urandom), $urandom,
                           neg_count(), neg_count(),
                           phase_type'($urandom_range(3)), 1'($urandom));
         end else begin
            r = event_item(4'($urandom));
         end
         push_item(r);
      end
   endtask

   initial begin
      board = new();
      reset = 1;
      items_sent = 0;
      tx_idle = 9;
      rx_idle = 54;
      req_bus.valid <= 0;
      req_bus.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // field extremes, each start phase, stop handling
      push_item(event_item(4'd0));
      push_item(event_item(4'd0));
      push_item(start_item(4'd15, DELAY_MAX, '0, 32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0001,
                           PH_ACCEL, 1'b1));
      repeat (4) push_item(event_item(4'd15));
      push_item(start_item(4'd1, '0, DELAY_MAX, '0, '0, '0, PH_RUN, 1'b0));
      repeat (4) push_item(event_item(4'd1));
      push_item(start_item(4'd2, 17'd1000, 17'd100, 32'd2, 32'hFFFF_FFFE, '0, PH_DECEL, 1'b1));
      repeat (6) push_item(event_item(4'd2));
      push_item(start_item(4'd3, 17'd9000, 17'd50, 32'd3, 32'hFFFF_FFFD, '0, PH_STOP, 1'b1));
      repeat (4) push_item(event_item(4'd3));

      for (int p = 0; p < 3; p++) begin
         tx_idle = (p == 0) ? 9 : (p == 1) ? 54 : 0;
         rx_idle = (p == 0) ? 54 : (p == 1) ? 9 : 0;
         while (items_sent < (p + 1) * PHASE_ITEMS) begin
            if ($urandom_range(99) < 80) run_move();
            else run_noise();
         end
      end
      req_bus.valid <= 0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0)
         $display("stepper_speed_ramp_generator_tb: clean");
      else
         $display("stepper_speed_ramp_generator_tb: errors");
      $finish;
   end

endmodule
